[hdl/point_depth_occlusion_cull_top_assert.svh]
// Assertion macros for the point depth occlusion cull block.
`ifndef POINT_DEPTH_OCCLUSION_CULL_TOP_ASSERT_SVH
`define POINT_DEPTH_OCCLUSION_CULL_TOP_ASSERT_SVH

// same-cycle implication
`define PDOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/pdoc_pkg.sv]
// Types, constants and helpers of the point depth occlusion cull block.
package pdoc_pkg;

  localparam int unsigned MAX_WIDTH       = 256;
  localparam int unsigned MAX_HEIGHT      = 256;
  localparam int unsigned DEPTH_FRAC_BITS = 24;
  localparam int unsigned POS_BITS        = 16;
  localparam int unsigned CLIP_W          = 49;
  localparam int unsigned DIV_W           = 50;
  localparam int unsigned LERP_W          = 27;

  localparam logic [24:0]               DEPTH_ONE   = 25'd16777216;
  localparam logic signed [LERP_W-1:0]  SAMPLE_FULL = 27'sd16777215;
  localparam logic signed [CLIP_W-1:0]  W_FAR       = 49'sd65536000000;

  localparam logic [8:0]  WIDTH_RST = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd256;
  localparam logic [7:0]  TOL_RST   = 8'd2;
  localparam logic [24:0] EMPTY_RST = 25'd16777199;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TEST  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_WIDTH    = 2'd0,
    CFG_ACTIVE_HEIGHT   = 2'd1,
    CFG_DEPTH_TOLERANCE = 2'd2,
    CFG_EMPTY_LEVEL     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DV_DEPTH = 2'd0,
    DV_U     = 2'd1,
    DV_V     = 2'd2
  } div_sel_e;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_PMUL = 15'b000000000000010,
    S_PACC = 15'b000000000000100,
    S_DSET = 15'b000000000001000,
    S_DIV  = 15'b000000000010000,
    S_DRES = 15'b000000000100000,
    S_XMUL = 15'b000000001000000,
    S_XSET = 15'b000000010000000,
    S_YMUL = 15'b000000100000000,
    S_YSET = 15'b000001000000000,
    S_RD   = 15'b000010000000000,
    S_ECHK = 15'b000100000000000,
    S_LMUL = 15'b001000000000000,
    S_LACC = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [15:0]        pixel_index;
    logic               has_point;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic        keep;
    logic [24:0] point_depth;
  } out_item_t;

  function automatic logic [8:0] eff_size(input logic [8:0] v, input logic [8:0] maxv);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[hdl/point_depth_occlusion_cull_top.sv]
// Point depth occlusion cull: projection, depth store and bilinear occlusion test.
// Every item runs through one shared 33x33 multiplier and one restoring divider
// (one quotient bit per cycle) under a one-hot sequencer; the block takes no new
// item until the current one is done. A coefficient load and an empty depth write
// complete in the idle state; a point depth write runs the projection
// multiply-accumulate steps and then the depth division, which is skipped when
// the depth clamps. A point test also runs the divider for the screen position,
// makes 4 pixel reads from the depth memory and takes 3 interpolation steps.
// A test that exits early (w not positive, far, off screen) skips the position
// division, the reads and the interpolation; a stalled result holds the block
// until it is taken.
// The depth store has no reset; a pixel must be written before it is sampled.
`include "point_depth_occlusion_cull_top_assert.svh"

module point_depth_occlusion_cull_top
  import pdoc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e state_q;
  in_item_t item_q;
  logic signed [31:0] mat_q [16];
  logic [8:0]  width_q, height_q;
  logic [7:0]  tol_q;
  logic [24:0] empty_q;

  logic [1:0] row_q, col_q;
  logic signed [CLIP_W-1:0] acc_q;
  logic signed [CLIP_W-1:0] clip_q [4];
  logic signed [65:0] prod_q;

  logic [DIV_W-1:0] rem_q, den_q;
  logic [23:0] quo_q;
  logic [4:0]  cnt_q;
  div_sel_e    sel_q;

  logic [24:0] depth_q;
  logic [15:0] u_q, v_q, fx_q, fy_q;
  logic [8:0]  x0_q, x1_q, y0_q, y1_q;
  logic [2:0]  rd_cnt_q;
  logic [24:0] corner_q [4];
  logic [24:0] rdata_q;
  logic [1:0]  lerp_q;
  logic signed [LERP_W-1:0] top_q, bot_q;
  logic keep_q;
  logic out_valid_q;
  out_item_t out_q;

  logic [24:0] mem [65536];

  logic [8:0] wd, ht, wd_m1, ht_m1;
  logic in_acc;
  logic signed [31:0] mat_rd, coord;
  logic signed [32:0] mul_a, mul_b;
  logic signed [CLIP_W-1:0] p_term, p_sum, w_c;
  logic signed [DIV_W-1:0] n_z, n_x, n_y, d_w;
  logic w_pos, offscreen;
  logic [DIV_W:0] r2, r_sub;
  logic ge;
  logic [23:0] quo_nx;
  logic [8:0] x0r, x0c, x1c, y0r, y0c, y1c;
  logic [8:0] ry, rx;
  logic [17:0] rd_sum;
  logic [15:0] rd_addr;
  logic signed [LERP_W-1:0] la, lb, l_diff, l_res;
  logic [15:0] l_f;
  logic signed [27:0] s_tol, d_cmp;
  logic any_empty;
  logic mem_we;
  logic [15:0] mem_wa;
  logic [24:0] mem_wd;
  logic [15:0] pix_sel;

  assign wd    = eff_size(width_q, 9'(MAX_WIDTH));
  assign ht    = eff_size(height_q, 9'(MAX_HEIGHT));
  assign wd_m1 = wd - 9'd1;
  assign ht_m1 = ht - 9'd1;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    mat_rd = mat_q[{row_q, col_q}];
    case (col_q)
      2'd0:    coord = item_q.point_x;
      2'd1:    coord = item_q.point_y;
      default: coord = item_q.point_z;
    endcase
    case (lerp_q)
      2'd0: begin
        la = $signed({2'b0, corner_q[0]});
        lb = $signed({2'b0, corner_q[1]});
      end
      2'd1: begin
        la = $signed({2'b0, corner_q[2]});
        lb = $signed({2'b0, corner_q[3]});
      end
      default: begin
        la = top_q;
        lb = bot_q;
      end
    endcase
    l_diff = lb - la;
    l_f    = (lerp_q == 2'd2) ? fy_q : fx_q;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_PMUL: begin
        mul_a = 33'(mat_rd);
        mul_b = 33'(coord);
      end
      S_XMUL: begin
        mul_a = $signed({17'b0, u_q});
        mul_b = $signed({24'b0, wd_m1});
      end
      S_YMUL: begin
        mul_a = $signed(33'(17'h10000 - {1'b0, v_q}));
        mul_b = $signed({24'b0, ht_m1});
      end
      S_LMUL: begin
        mul_a = 33'(l_diff);
        mul_b = $signed({17'b0, l_f});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_term = CLIP_W'(prod_q >>> 16);
  assign p_sum  = ((col_q == 2'd0) ? CLIP_W'(mat_q[{row_q, 2'd3}]) : acc_q) + p_term;

  assign w_c   = clip_q[3];
  assign w_pos = (w_c > 0);
  assign n_z   = DIV_W'(clip_q[2]) + DIV_W'(w_c);
  assign n_x   = DIV_W'(clip_q[0]) + DIV_W'(w_c);
  assign n_y   = DIV_W'(clip_q[1]) + DIV_W'(w_c);
  assign d_w   = DIV_W'(w_c) <<< 1;
  assign offscreen = (clip_q[0] < -w_c) || (clip_q[0] >= w_c) ||
                     (clip_q[1] < -w_c) || (clip_q[1] >= w_c);

  assign r2     = {rem_q, 1'b0};
  assign ge     = (r2 >= {1'b0, den_q});
  assign r_sub  = r2 - {1'b0, den_q};
  assign quo_nx = {quo_q[22:0], ge};

  assign x0r = {1'b0, prod_q[23:16]};
  assign x0c = (x0r > wd_m1) ? wd_m1 : x0r;
  assign x1c = ((x0c + 9'd1) < wd) ? x0c + 9'd1 : wd_m1;
  assign y0r = prod_q[24:16];
  assign y0c = (y0r > ht_m1) ? ht_m1 : y0r;
  assign y1c = ((y0c + 9'd1) < ht) ? y0c + 9'd1 : ht_m1;

  assign ry      = rd_cnt_q[1] ? y1_q : y0_q;
  assign rx      = rd_cnt_q[0] ? x1_q : x0_q;
  assign rd_sum  = 18'(ry) * 18'(wd) + 18'(rx);
  assign rd_addr = rd_sum[15:0];

  assign l_res = la + LERP_W'(prod_q >>> 16);
  assign s_tol = 28'(l_res) + $signed({20'b0, tol_q});
  assign d_cmp = $signed({3'b0, depth_q});

  assign any_empty = (corner_q[0] >= empty_q) || (corner_q[1] >= empty_q) ||
                     (corner_q[2] >= empty_q) || (corner_q[3] >= empty_q);

  always_comb begin
    pix_sel = (state_q == S_DRES) ? item_q.pixel_index : in_item_i.pixel_index;
    mem_wa  = pix_sel;
    mem_wd  = (state_q == S_DRES) ? depth_q : DEPTH_ONE;
    mem_we  = 1'b0;
    if ({1'b0, pix_sel} < 17'(wd) * 17'(ht)) begin
      if (state_q == S_DRES) begin
        mem_we = (item_q.func == FUNC_WRITE);
      end else if (in_acc) begin
        mem_we = (in_item_i.func == FUNC_WRITE) && !in_item_i.has_point;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      tol_q    <= TOL_RST;
      empty_q  <= EMPTY_RST;
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      row_q    <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
      rd_cnt_q <= '0;
      lerp_q   <= '0;
      sel_q    <= DV_DEPTH;
    end else begin
      prod_q <= mul_a * mul_b;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ACTIVE_WIDTH:    width_q  <= cfg_data_i[8:0];
          CFG_ACTIVE_HEIGHT:   height_q <= cfg_data_i[8:0];
          CFG_DEPTH_TOLERANCE: tol_q    <= cfg_data_i[7:0];
          CFG_EMPTY_LEVEL:     empty_q  <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            item_q <= in_item_i;
            row_q  <= '0;
            col_q  <= '0;
            if (in_item_i.func == FUNC_LOAD) begin
              mat_q[in_item_i.coef_index] <= in_item_i.coef_value;
            end else if ((in_item_i.func == FUNC_WRITE && in_item_i.has_point) ||
                         in_item_i.func == FUNC_TEST) begin
              state_q <= S_PMUL;
            end
          end
        end
        S_PMUL: state_q <= S_PACC;
        S_PACC: begin
          if (col_q == 2'd2) begin
            clip_q[row_q] <= p_sum;
            col_q <= '0;
            row_q <= row_q + 2'd1;
            state_q <= (row_q == 2'd3) ? S_DSET : S_PMUL;
          end else begin
            acc_q <= p_sum;
            col_q <= col_q + 2'd1;
            state_q <= S_PMUL;
          end
        end
        S_DSET: begin
          if (!w_pos || n_z <= 0) begin
            depth_q <= '0;
            state_q <= S_DRES;
          end else if (n_z >= d_w) begin
            depth_q <= DEPTH_ONE;
            state_q <= S_DRES;
          end else begin
            rem_q   <= n_z;
            den_q   <= d_w;
            quo_q   <= '0;
            cnt_q   <= 5'(DEPTH_FRAC_BITS);
            sel_q   <= DV_DEPTH;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= ge ? r_sub[DIV_W-1:0] : r2[DIV_W-1:0];
          quo_q <= quo_nx;
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd1) begin
            case (sel_q)
              DV_DEPTH: begin
                depth_q <= {1'b0, quo_nx};
                state_q <= S_DRES;
              end
              DV_U: begin
                u_q   <= quo_nx[15:0];
                rem_q <= n_y;
                quo_q <= '0;
                cnt_q <= 5'(POS_BITS);
                sel_q <= DV_V;
              end
              default: begin
                v_q     <= quo_nx[15:0];
                state_q <= S_XMUL;
              end
            endcase
          end
        end
        S_DRES: begin
          if (item_q.func == FUNC_WRITE) begin
            state_q <= S_IDLE;
          end else if (!w_pos || w_c >= W_FAR || offscreen) begin
            keep_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            rem_q   <= n_x;
            den_q   <= d_w;
            quo_q   <= '0;
            cnt_q   <= 5'(POS_BITS);
            sel_q   <= DV_U;
            state_q <= S_DIV;
          end
        end
        S_XMUL: state_q <= S_XSET;
        S_XSET: begin
          x0_q <= x0c;
          x1_q <= x1c;
          fx_q <= prod_q[15:0];
          state_q <= S_YMUL;
        end
        S_YMUL: state_q <= S_YSET;
        S_YSET: begin
          y0_q <= y0c;
          y1_q <= y1c;
          fy_q <= prod_q[15:0];
          rd_cnt_q <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (rd_cnt_q != 3'd0) begin
            corner_q[2'(rd_cnt_q - 3'd1)] <= rdata_q;
          end
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == 3'd4) begin
            state_q <= S_ECHK;
          end
        end
        S_ECHK: begin
          lerp_q <= '0;
          if (any_empty) begin
            keep_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_LMUL;
          end
        end
        S_LMUL: state_q <= S_LACC;
        S_LACC: begin
          lerp_q <= lerp_q + 2'd1;
          if (lerp_q == 2'd0) begin
            top_q   <= l_res;
            state_q <= S_LMUL;
          end else if (lerp_q == 2'd1) begin
            bot_q   <= l_res;
            state_q <= S_LMUL;
          end else begin
            keep_q  <= (l_res >= SAMPLE_FULL) || !(d_cmp < s_tol);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q       <= 1'b1;
            out_q.keep        <= keep_q;
            out_q.point_depth <= depth_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PDOC_ASSERT_NOW(a_div_rem_below, (state_q == S_DIV), (rem_q < den_q), "divider remainder overflow")
  `PDOC_ASSERT_NEXT(a_proj_to_depth, (state_q == S_PACC && col_q == 2'd2 && row_q == 2'd3), (state_q == S_DSET), "projection did not finish")
  `PDOC_ASSERT_NOW(a_out_from_done, $rose(out_valid_o), $past(state_q == S_DONE), "result without finished test")

endmodule
